/* hw/rtl/dpss_pkg.sv */
package dpss_pkg;

    // Field widths of the item and register formats.
    localparam int DT_W     = 16;
    localparam int CAM_W    = 16;
    localparam int Q12_W    = 24;
    localparam int MAXV_W   = 23;
    localparam int CFG_IDX_W = 4;

    // Default depth of the quarter-wave sine table, as log2 of its step count.
    localparam int SINE_TABLE_BITS_DEF = 8;

    // Roll coupling into the down angle, Q.12 (4096 is a gain of one).
    localparam logic signed [14:0] ROLL_GAIN = 15'sd0;

    // 1/(2*pi) in Q32, turns radians Q.12 into a phase in turns.
    localparam logic signed [31:0] INV_TWO_PI_Q32 = 32'sd683565276;

    // pi/2 in Q30, used only while the sine table is built.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRICTION  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VEL   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MIN = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MAX = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_MIN  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_MAX  = 4'd7;

    // Divides a Taylor term by (2k)(2k+1) for the term of order k.
    function automatic logic [63:0] taylor_div(input logic [63:0] term, input int k);
        logic [63:0] q;
        case (k)
            1:       q = term / 64'd6;
            2:       q = term / 64'd20;
            3:       q = term / 64'd42;
            4:       q = term / 64'd72;
            5:       q = term / 64'd110;
            6:       q = term / 64'd156;
            default: q = term;
        endcase
        return q;
    endfunction

    // Quarter-wave sine table entry, Q1.12, evaluated from a Taylor series in Q30.
    function automatic logic [12:0] rom_entry(input int unsigned idx, input int unsigned bits);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] rnd;
        x    = (HALF_PI_Q30 * 64'(idx)) >> bits;
        term = x;
        sum  = $signed(x);
        for (int k = 1; k <= 6; k++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = taylor_div(term, k);
            if (k[0])
            begin
                sum = sum - $signed(term);
            end
            else
            begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        rnd = (sum + 64'sd131072) >>> 18;
        return rnd[12:0];
    endfunction

endpackage

/* hw/rtl/damped_pendulum_sway_step_top.sv */
// Damped pendulum sway integrator. Each input item (time step, camera pitch and roll,
// signed player speed) advances a swinging angle and its angular velocity by one
// explicit Euler step and returns one result item with the new angle, the new velocity
// and a flag that is set when the angle hit a limit and the velocity was zeroed. All
// values are signed Q11.12 except the time step (unsigned Q0.16) and the camera angles
// (Q3.12). After an item is taken in it runs through fifteen sequencer steps, nine of
// which are passes through a single shared 32 by 32 bit signed multiplier, and the
// block takes no new item until the last step is done.
// The result waits in an output register, and if the sink stalls, the last step holds
// until the register is free. The sine of the angle error comes from a quarter-wave
// table of 2^SINE_TABLE_BITS+1 entries with a registered read. Configuration writes
// are taken whenever the block is out of reset and must only be made while no item
// is in flight. Neither channel is ready while reset is asserted.
module damped_pendulum_sway_step_top #(
    parameter int SINE_TABLE_BITS = dpss_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, from bit 0 up: time_step[15:0], camera_pitch[15:0],
    // camera_roll[15:0], player_speed[23:0].
    input  logic [71:0] s_tdata,
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, from bit 0 up: sway_angle_out[23:0], sway_velocity_out[23:0].
    output logic [47:0] m_tdata,
    // m_tuser, from bit 0 up: at_limit.
    output logic [0:0]  m_tuser,
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [dpss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int TableN = 1 << SINE_TABLE_BITS;
    localparam int IdxW   = SINE_TABLE_BITS + 1;

    // Sequencer steps. Each multiply step loads the shared multiplier; the step
    // after it consumes the registered product.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ROLL  = 4'd1;   // roll * ROLL_GAIN
    localparam logic [3:0] ST_DOWN  = 4'd2;   // clamp down angle, form angle error
    localparam logic [3:0] ST_PHASE = 4'd3;   // error * 1/(2 pi)
    localparam logic [3:0] ST_SINE  = 4'd4;   // table read
    localparam logic [3:0] ST_DTS   = 4'd5;   // dt * sine
    localparam logic [3:0] ST_GRAV  = 4'd6;   // (dt * sine) * gravity
    localparam logic [3:0] ST_SPEED = 4'd7;   // apply gravity, speed * speed_gain
    localparam logic [3:0] ST_CAP   = 4'd8;   // apply speed kick, cap velocity
    localparam logic [3:0] ST_VDT   = 4'd9;   // v * dt
    localparam logic [3:0] ST_FHI   = 4'd10;  // upper part of v*dt times friction
    localparam logic [3:0] ST_FLO   = 4'd11;  // lower part of v*dt times friction
    localparam logic [3:0] ST_DAMP  = 4'd12;  // sum the friction partial products
    localparam logic [3:0] ST_SAT   = 4'd13;  // subtract damping and saturate
    localparam logic [3:0] ST_ADT   = 4'd14;  // damped v * dt
    localparam logic [3:0] ST_ANGLE = 4'd15;  // integrate angle, apply limits

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Configuration registers.
    logic signed [23:0] gravity_reg;
    logic signed [23:0] friction_reg;
    logic signed [23:0] speedg_reg;
    logic        [22:0] maxvel_reg;
    logic signed [23:0] amin_reg;
    logic signed [23:0] amax_reg;
    logic signed [23:0] dmin_reg;
    logic signed [23:0] dmax_reg;

    // Pendulum state.
    logic signed [23:0] angle_reg;
    logic signed [23:0] velocity_reg;

    // Latched input item.
    logic        [15:0] dt_reg;
    logic signed [15:0] pitch_reg;
    logic signed [15:0] roll_reg;
    logic signed [23:0] speed_reg;

    // Working registers.
    logic signed [63:0] prod_reg;
    logic signed [25:0] rad_reg;
    logic signed [13:0] sine_reg;
    logic signed [26:0] vacc_reg;
    logic signed [23:0] vwork_reg;
    logic        [15:0] lo_reg;
    logic signed [47:0] acc_reg;
    logic signed [35:0] fric_reg;

    // Output register.
    logic               m_valid_reg;
    logic        [47:0] m_data_reg;
    logic               m_limit_reg;

    // Shared multiplier operands.
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic               mul_en;

    // Datapath intermediates.
    logic signed [18:0] roll_term;
    logic signed [19:0] down_raw;
    logic signed [24:0] down_clamp;
    logic signed [25:0] rad_next;
    logic        [31:0] phase;
    logic        [SINE_TABLE_BITS-1:0] frac;
    logic        [IdxW-1:0] rom_idx;
    logic signed [13:0] sine_next;
    logic signed [25:0] grav_term;
    logic signed [26:0] vacc_next;
    logic signed [35:0] speed_term;
    logic signed [36:0] vcap_sum;
    logic signed [36:0] cap_hi;
    logic signed [23:0] vcap;
    logic signed [63:0] damp_total;
    logic signed [36:0] sat_diff;
    logic signed [23:0] vsat;
    logic signed [23:0] angle_step;
    logic signed [24:0] angle_sum;
    logic signed [24:0] angle_lo;
    logic signed [23:0] angle_new;
    logic               lim_lo;
    logic               lim_hi;
    logic signed [23:0] vel_new;

    logic               out_free;

    // Quarter-wave table, built at elaboration and read through a register.
    logic [12:0] sine_rom [TableN+1];

    for (genvar gi = 0; gi <= TableN; gi++)
    begin : g_rom
        assign sine_rom[gi] = dpss_pkg::rom_entry(gi, SINE_TABLE_BITS);
    end

    assign s_tready  = rst_n && (state_reg == ST_IDLE);
    assign cfg_ready = rst_n;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_limit_reg;

    // The output register can take a new result when empty or being drained.
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_ROLL;
                end
            end
            ST_ANGLE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = state_reg + 4'd1;
            end
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a  = 32'sd0;
        mul_b  = 32'sd0;
        mul_en = 1'b1;
        case (state_reg)
            ST_ROLL:
            begin
                mul_a = 32'(roll_reg);
                mul_b = 32'(dpss_pkg::ROLL_GAIN);
            end
            ST_PHASE:
            begin
                mul_a = 32'(rad_reg);
                mul_b = dpss_pkg::INV_TWO_PI_Q32;
            end
            ST_DTS:
            begin
                mul_a = $signed({16'd0, dt_reg});
                mul_b = 32'(sine_reg);
            end
            ST_GRAV:
            begin
                mul_a = prod_reg[31:0];
                mul_b = 32'(gravity_reg);
            end
            ST_SPEED:
            begin
                mul_a = 32'(speed_reg);
                mul_b = 32'(speedg_reg);
            end
            ST_VDT, ST_ADT:
            begin
                mul_a = 32'(vwork_reg);
                mul_b = $signed({16'd0, dt_reg});
            end
            ST_FHI:
            begin
                mul_a = 32'($signed(prod_reg[39:16]));
                mul_b = 32'(friction_reg);
            end
            ST_FLO:
            begin
                mul_a = $signed({16'd0, lo_reg});
                mul_b = 32'(friction_reg);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Arithmetic of the individual steps; every right shift is an arithmetic shift,
    // which rounds toward minus infinity.
    always_comb
    begin
        // Down angle from pitch and roll, clamped lower limit first.
        roll_term = prod_reg[30:12];
        down_raw  = 20'(roll_term) - 20'(pitch_reg);
        if (25'(down_raw) < 25'(dmin_reg))
        begin
            down_clamp = 25'(dmin_reg);
        end
        else if (25'(down_raw) > 25'(dmax_reg))
        begin
            down_clamp = 25'(dmax_reg);
        end
        else
        begin
            down_clamp = 25'(down_raw);
        end
        rad_next = 26'(angle_reg) - 26'(down_clamp);

        // Phase in turns: quadrant in the top two bits, table index below.
        phase = prod_reg[43:12];
        frac  = phase[29 -: SINE_TABLE_BITS];
        if (phase[30])
        begin
            rom_idx = IdxW'(TableN) - {1'b0, frac};
        end
        else
        begin
            rom_idx = {1'b0, frac};
        end
        if (phase[31])
        begin
            sine_next = -$signed({1'b0, sine_rom[rom_idx]});
        end
        else
        begin
            sine_next = $signed({1'b0, sine_rom[rom_idx]});
        end

        // Gravity pull, then player speed kick, then the velocity cap.
        grav_term  = prod_reg[53:28];
        vacc_next  = 27'(velocity_reg) - 27'(grav_term);
        speed_term = prod_reg[47:12];
        vcap_sum   = 37'(vacc_reg) - 37'(speed_term);
        cap_hi     = $signed({14'd0, maxvel_reg});
        if (vcap_sum > cap_hi)
        begin
            vcap = 24'(cap_hi);
        end
        else if (vcap_sum < -cap_hi)
        begin
            vcap = 24'(-cap_hi);
        end
        else
        begin
            vcap = 24'(vcap_sum);
        end

        // Friction: v*dt*friction from two partial products.
        damp_total = (64'(acc_reg) <<< 16) + prod_reg;
        sat_diff   = 37'(vwork_reg) - 37'(fric_reg);
        if (sat_diff > 37'sd8388607)
        begin
            vsat = 24'sh7FFFFF;
        end
        else if (sat_diff < -37'sd8388608)
        begin
            vsat = 24'sh800000;
        end
        else
        begin
            vsat = 24'(sat_diff);
        end

        // Angle update and limits, the lower limit tested first.
        angle_step = prod_reg[39:16];
        angle_sum  = 25'(angle_reg) + 25'(angle_step);
        lim_lo     = angle_sum < 25'(amin_reg);
        angle_lo   = lim_lo ? 25'(amin_reg) : angle_sum;
        lim_hi     = angle_lo > 25'(amax_reg);
        angle_new  = lim_hi ? amax_reg : 24'(angle_lo);
        vel_new    = (lim_lo || lim_hi) ? 24'sd0 : vwork_reg;
    end

    // Control, configuration and pendulum state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            gravity_reg  <= '0;
            friction_reg <= '0;
            speedg_reg   <= '0;
            maxvel_reg   <= '0;
            amin_reg     <= '0;
            amax_reg     <= '0;
            dmin_reg     <= '0;
            dmax_reg     <= '0;
            angle_reg    <= '0;
            velocity_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                case (cfg_index)
                    dpss_pkg::CFG_GRAVITY:   gravity_reg  <= cfg_data;
                    dpss_pkg::CFG_FRICTION:  friction_reg <= cfg_data;
                    dpss_pkg::CFG_SPEED:     speedg_reg   <= cfg_data;
                    dpss_pkg::CFG_MAX_VEL:   maxvel_reg   <= cfg_data[22:0];
                    dpss_pkg::CFG_ANGLE_MIN: amin_reg     <= cfg_data;
                    dpss_pkg::CFG_ANGLE_MAX: amax_reg     <= cfg_data;
                    dpss_pkg::CFG_DOWN_MIN:  dmin_reg     <= cfg_data;
                    dpss_pkg::CFG_DOWN_MAX:  dmax_reg     <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == ST_ANGLE && out_free)
            begin
                m_valid_reg  <= 1'b1;
                angle_reg    <= angle_new;
                velocity_reg <= vel_new;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= 64'(mul_a) * 64'(mul_b);
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    dt_reg    <= s_tdata[15:0];
                    pitch_reg <= s_tdata[31:16];
                    roll_reg  <= s_tdata[47:32];
                    speed_reg <= s_tdata[71:48];
                end
            end
            ST_DOWN:  rad_reg   <= rad_next;
            ST_SINE:  sine_reg  <= sine_next;
            ST_SPEED: vacc_reg  <= vacc_next;
            ST_CAP:   vwork_reg <= vcap;
            ST_FHI:   lo_reg    <= prod_reg[15:0];
            ST_FLO:   acc_reg   <= prod_reg[47:0];
            ST_DAMP:  fric_reg  <= damp_total[63:28];
            ST_SAT:   vwork_reg <= vsat;
            ST_ANGLE:
            begin
                if (out_free)
                begin
                    m_data_reg  <= {vel_new, angle_new};
                    m_limit_reg <= lim_lo || lim_hi;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* hw/rtl/dpss_checker.sv */
module dpss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // The block works on one item at a time.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while busy");

    // No result can appear the cycle after an item is taken in.
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result too early");

    // A clamped angle always comes with zero velocity.
    a_limit_vel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[47:24] == 24'd0)
        else $error("limit flag with nonzero velocity");

endmodule

bind damped_pendulum_sway_step_top dpss_checker u_checker (.*);
